>>> hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the beep pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int NUM_PATTERNS = 3;
	localparam int PAT_W        = 40;
	localparam int TICK_W       = 16;
	localparam int REP_W        = 8;
	localparam int MODE_W       = 2;
	localparam int FUNC_W       = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [TICK_W-1:0] STOP_SILENCE = 16'hFFFF;
	localparam logic [TICK_W-1:0] SINGLE_TICKS = 16'd3;

	localparam logic [PAT_W-1:0] PATTERN1_RESET = 40'h01_2C03_2801;
	localparam logic [PAT_W-1:0] PATTERN2_RESET = 40'h00_0000_3232;
	localparam logic [PAT_W-1:0] PATTERN3_RESET = 40'hFF_FF02_0A05;

	typedef logic [PAT_W-1:0] pattern_t;
	typedef pattern_t [NUM_PATTERNS-1:0] pattern_set_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_SET    = 2'd1,
		FUNC_SINGLE = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		PH_BEEP    = 3'b001,
		PH_SILENCE = 3'b010,
		PH_LONG    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [MODE_W-1:0] active_mode;
		phase_t            phase;
		logic [REP_W-1:0]  repeat_count;
		logic [TICK_W-1:0] ticks_left;
		logic              timer_running;
		logic              single_pending;
		logic              drive_level;
	} seq_state_t;

	function automatic logic [7:0] pat_beep(input pattern_t p);
		return p[7:0];
	endfunction

	function automatic logic [7:0] pat_silence(input pattern_t p);
		return p[15:8];
	endfunction

	function automatic logic [REP_W-1:0] pat_repeat(input pattern_t p);
		return p[23:16];
	endfunction

	function automatic logic [TICK_W-1:0] pat_long(input pattern_t p);
		return p[39:24];
	endfunction

endpackage

>>> hw/rtl/bps_step.sv
// ----------------------------------------------------------------------------
// bps_step
// Next-state logic of the sequencer for one tick, set-mode or single-beep beat.
// ----------------------------------------------------------------------------
module bps_step (
	input  bps_pkg::seq_state_t             cur,
	input  logic [bps_pkg::FUNC_W-1:0]      func,
	input  logic [bps_pkg::MODE_W-1:0]      mode,
	input  bps_pkg::pattern_set_t           patterns,
	output bps_pkg::seq_state_t             nxt
);
	import bps_pkg::*;

	pattern_t         pat_act;
	pattern_t         pat_req;
	logic [REP_W-1:0] rc_inc;
	logic             set_ignore;

	assign pat_act = (cur.active_mode == '0) ? '0 : patterns[cur.active_mode - 2'd1];
	assign pat_req = (mode == '0) ? '0 : patterns[mode - 2'd1];
	assign rc_inc  = cur.repeat_count + 8'd1;
	assign set_ignore = ((cur.active_mode > mode) && (mode != '0)) || (cur.active_mode == mode);

	always_comb begin
		nxt = cur;
		case (func)
			FUNC_TICK: begin
				if (cur.timer_running) begin
					if (cur.ticks_left > 16'd1) begin
						nxt.ticks_left = cur.ticks_left - 16'd1;
					end else begin
						nxt.ticks_left = '0;
						if (cur.single_pending) begin
							nxt.single_pending = 1'b0;
							if (cur.active_mode == '0) begin
								nxt.timer_running = 1'b0;
								nxt.drive_level   = 1'b0;
							end else begin
								nxt.phase         = PH_BEEP;
								nxt.repeat_count  = '0;
								nxt.ticks_left    = {8'd0, pat_beep(pat_act)};
								nxt.timer_running = 1'b1;
								nxt.drive_level   = 1'b1;
							end
						end else begin
							case (cur.phase)
								PH_BEEP: begin
									nxt.drive_level   = 1'b0;
									nxt.phase         = PH_SILENCE;
									nxt.ticks_left    = {8'd0, pat_silence(pat_act)};
									nxt.timer_running = 1'b1;
								end
								PH_SILENCE: begin
									nxt.repeat_count = rc_inc;
									if (rc_inc >= pat_repeat(pat_act)) begin
										if (pat_long(pat_act) == STOP_SILENCE) begin
											if (cur.active_mode != '0) begin
												nxt.active_mode   = '0;
												nxt.timer_running = 1'b0;
												nxt.ticks_left    = '0;
												nxt.drive_level   = 1'b0;
											end
										end else begin
											nxt.phase         = PH_LONG;
											nxt.repeat_count  = '0;
											nxt.ticks_left    = pat_long(pat_act);
											nxt.timer_running = 1'b1;
										end
									end else begin
										nxt.drive_level   = 1'b1;
										nxt.phase         = PH_BEEP;
										nxt.ticks_left    = {8'd0, pat_beep(pat_act)};
										nxt.timer_running = 1'b1;
									end
								end
								default: begin
									nxt.drive_level   = 1'b1;
									nxt.phase         = PH_BEEP;
									nxt.ticks_left    = {8'd0, pat_beep(pat_act)};
									nxt.timer_running = 1'b1;
								end
							endcase
						end
					end
				end
			end
			FUNC_SET: begin
				if (!set_ignore) begin
					nxt.active_mode = mode;
					if (mode == '0) begin
						nxt.timer_running = 1'b0;
						nxt.ticks_left    = '0;
						nxt.drive_level   = 1'b0;
					end else begin
						nxt.single_pending = 1'b0;
						nxt.phase          = PH_BEEP;
						nxt.repeat_count   = '0;
						nxt.ticks_left     = {8'd0, pat_beep(pat_req)};
						nxt.timer_running  = 1'b1;
						nxt.drive_level    = 1'b1;
					end
				end
			end
			FUNC_SINGLE: begin
				if (cur.active_mode == '0) begin
					nxt.single_pending = 1'b1;
					nxt.ticks_left     = SINGLE_TICKS;
					nxt.timer_running  = 1'b1;
					nxt.drive_level    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/beep_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Buzzer pattern sequencer driven by tick, set-mode and single-beep beats.
//
//   channel  | direction | tdata / data                 | tuser / index
//   s_axis   | in        | [1:0] mode                   | [1:0] func
//   m_axis   | out       | [0] buzzer_on, [2:1] mode    | -
//   cfg      | in        | [39:0] pattern word          | [1:0] register
//
// One beat is accepted per cycle while m_axis is not stalled; its result reaches m_axis
// through an input register and then a result register around the state update.
// Reset clears the sequencer state and loads the default patterns.
// A stall on m_axis holds the result and fills the input register, then
// s_axis_tready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [1:0] mode
	input  logic [bps_pkg::FUNC_W-1:0]      s_axis_tuser,  // [1:0] func
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [0] buzzer_on, [2:1] current_mode
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bps_pkg::PAT_W-1:0]       cfg_data
);
	import bps_pkg::*;

	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [MODE_W-1:0] mode_s1;
	logic              advance;
	pattern_set_t      patterns_q;
	seq_state_t        state_q;
	seq_state_t        state_nxt;
	logic              out_valid_q;
	logic              buzzer_q;
	logic [MODE_W-1:0] cur_mode_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tuser;
			mode_s1 <= s_axis_tdata[MODE_W-1:0];
		end
	end

	// pattern registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patterns_q[0] <= PATTERN1_RESET;
			patterns_q[1] <= PATTERN2_RESET;
			patterns_q[2] <= PATTERN3_RESET;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_PATTERNS))) begin
			patterns_q[cfg_index] <= cfg_data;
		end
	end

	bps_step u_step (
		.cur      (state_q),
		.func     (func_s1),
		.mode     (mode_s1),
		.patterns (patterns_q),
		.nxt      (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{active_mode: '0, phase: PH_BEEP, repeat_count: '0, ticks_left: '0,
				timer_running: 1'b0, single_pending: 1'b0, drive_level: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buzzer_q   <= state_nxt.drive_level;
			cur_mode_q <= state_nxt.active_mode;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, cur_mode_q, buzzer_q};

endmodule

>>> tb/sv/beep_sequence_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beep_sequence_checker
// Watches the input, result and register write channels of the beep pattern
// sequencer. It keeps its own copy of the pattern words and of the sequencer
// state, works out the buzzer level and active mode after every input beat,
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module beep_sequence_checker
	import bps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,
	input  logic [FUNC_W-1:0]    s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [7:0]           m_axis_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	output int                   pending,
	output int                   errors
);

	typedef struct packed {
		logic              buzzer_on;
		logic [MODE_W-1:0] current_mode;
	} buzz_state_t;

	pattern_set_t      patterns;
	logic [MODE_W-1:0] active_mode;
	phase_t            phase;
	logic [REP_W-1:0]  repeat_count;
	logic [TICK_W-1:0] ticks_left;
	logic              timer_running;
	logic              single_pending;
	logic              drive_level;

	buzz_state_t expected_q[$];
	buzz_state_t got;
	buzz_state_t want;
	int          fails;

	function automatic pattern_t pattern_for(input logic [MODE_W-1:0] m);
		if (m == 0)
			return '0;
		return patterns[m - 1];
	endfunction

	task automatic arm_timer(input logic [TICK_W-1:0] len);
		ticks_left = len;
		timer_running = 1'b1;
	endtask

	task automatic start_pattern(input logic [MODE_W-1:0] m);
		pattern_t p;
		p = pattern_for(m);
		single_pending = 1'b0;
		phase = PH_BEEP;
		repeat_count = '0;
		arm_timer({8'd0, p[7:0]});
		drive_level = 1'b1;
	endtask

	task automatic select_mode(input logic [MODE_W-1:0] m, input logic restart);
		if (!restart && ((active_mode > m && m != 0) || active_mode == m))
			return;
		active_mode = m;
		if (m == 0) begin
			timer_running = 1'b0;
			ticks_left = '0;
			drive_level = 1'b0;
		end else begin
			start_pattern(m);
		end
	endtask

	task automatic advance_tick();
		pattern_t          p;
		logic [TICK_W-1:0] long_len;
		if (!timer_running)
			return;
		if (ticks_left > 1) begin
			ticks_left = ticks_left - 1'b1;
			return;
		end
		ticks_left = '0;
		if (single_pending) begin
			single_pending = 1'b0;
			select_mode(active_mode, 1'b1);
			return;
		end
		p = pattern_for(active_mode);
		long_len = p[39:24];
		case (phase)
			PH_BEEP: begin
				drive_level = 1'b0;
				phase = PH_SILENCE;
				arm_timer({8'd0, p[15:8]});
			end
			PH_SILENCE: begin
				repeat_count = repeat_count + 1'b1;
				if (repeat_count >= p[23:16]) begin
					if (long_len == STOP_SILENCE) begin
						select_mode('0, 1'b0);
						return;
					end
					phase = PH_LONG;
					repeat_count = '0;
					arm_timer(long_len);
				end else begin
					drive_level = 1'b1;
					phase = PH_BEEP;
					arm_timer({8'd0, p[7:0]});
				end
			end
			default: begin
				drive_level = 1'b1;
				phase = PH_BEEP;
				arm_timer({8'd0, p[7:0]});
			end
		endcase
	endtask

	task automatic apply_beat(input logic [FUNC_W-1:0] func, input logic [MODE_W-1:0] m);
		case (func)
			FUNC_TICK:   advance_tick();
			FUNC_SET:    select_mode(m, 1'b0);
			FUNC_SINGLE: begin
				if (active_mode == 0) begin
					single_pending = 1'b1;
					arm_timer(SINGLE_TICKS);
					drive_level = 1'b1;
				end
			end
			default: ;
		endcase
		expected_q.push_back({drive_level, active_mode});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patterns[0] = PATTERN1_RESET;
			patterns[1] = PATTERN2_RESET;
			patterns[2] = PATTERN3_RESET;
			active_mode = '0;
			phase = PH_BEEP;
			repeat_count = '0;
			ticks_left = '0;
			timer_running = 1'b0;
			single_pending = 1'b0;
			drive_level = 1'b0;
			expected_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			fails = 0;
			if (cfg_valid && cfg_ready && cfg_index < NUM_PATTERNS)
				patterns[cfg_index] = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				apply_beat(s_axis_tuser, s_axis_tdata[MODE_W-1:0]);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[0], m_axis_tdata[2:1]};
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, got buzzer_on=%0d mode=%0d",
						$time, got.buzzer_on, got.current_mode);
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (got.buzzer_on !== want.buzzer_on) begin
						$display("%0t: buzzer_on expected %0d got %0d",
							$time, want.buzzer_on, got.buzzer_on);
						fails++;
					end
					if (got.current_mode !== want.current_mode) begin
						$display("%0t: current_mode expected %0d got %0d",
							$time, want.current_mode, got.current_mode);
						fails++;
					end
				end
			end
			pending <= expected_q.size();
			errors <= errors + fails;
		end
	end

endmodule

>>> tb/sv/beep_pattern_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_tb
// Drives tick, set-mode, single-beep and unused-function beats into the beep
// pattern sequencer, a directed opening and then random runs under several pattern
// settings and throttling mixes, and leaves prediction and comparison to the
// checker beside the block. Gives the verdict from its error count.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer_tb;
	import bps_pkg::*;

	localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN3 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
	localparam int IDLE_LIMIT     = 5000;
	localparam int SETTINGS_COUNT = 6;
	localparam int ITEMS_PER_SET  = 255;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic [FUNC_W-1:0]    s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_data;
	int                   pending;
	int                   errors;
	int                   tx_idle_pct;
	int                   rx_idle_pct;
	int                   quiet_cycles;

	beep_pattern_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	beep_sequence_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.errors        (errors)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// nothing accepted for too long means the block is stuck
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	task automatic send_item(input logic [FUNC_W-1:0] func, input logic [MODE_W-1:0] m);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {6'd0, m};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random_item();
		int                r;
		logic [MODE_W-1:0] m;
		r = $urandom_range(0, 99);
		m = MODE_W'($urandom_range(0, 3));
		if (r < 70)
			send_item(FUNC_TICK, m);
		else if (r < 85)
			send_item(FUNC_SET, m);
		else if (r < 97)
			send_item(FUNC_SINGLE, m);
		else
			send_item(FUNC_UNUSED, m);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_pattern(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic pattern_t random_pattern();
		logic [15:0] long_len;
		long_len = ($urandom_range(0, 2) == 0) ? STOP_SILENCE : 16'($urandom_range(0, 6));
		return {long_len, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
			8'($urandom_range(0, 4))};
	endfunction

	task automatic configure(input int setting);
		if (setting == 0) begin
			write_pattern(REG_PATTERN1, '0);
			write_pattern(REG_PATTERN2, '0);
			write_pattern(REG_PATTERN3, '0);
			write_pattern(REG_UNUSED, '1);
		end else if (setting == 1) begin
			write_pattern(REG_PATTERN1, '1);
			write_pattern(REG_PATTERN2, '1);
			write_pattern(REG_PATTERN3, '1);
		end else begin
			write_pattern(REG_PATTERN1, random_pattern());
			write_pattern(REG_PATTERN2, random_pattern());
			write_pattern(REG_PATTERN3, random_pattern());
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_PATTERN1;
		cfg_data = '0;
		tx_idle_pct = 34;
		rx_idle_pct = 83;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening with the reset patterns
		send_item(FUNC_UNUSED, 2'd3);
		send_item(FUNC_SINGLE, 2'd0);
		send_item(FUNC_TICK, 2'd3);
		send_item(FUNC_SET, 2'd3);
		send_item(FUNC_SINGLE, 2'd1);
		send_item(FUNC_SET, 2'd1);
		send_item(FUNC_SET, 2'd3);
		repeat (5) send_item(FUNC_TICK, 2'd2);
		send_item(FUNC_SET, 2'd0);
		send_item(FUNC_SINGLE, 2'd3);
		repeat (3) send_item(FUNC_TICK, 2'd1);
		send_item(FUNC_SET, 2'd1);
		send_item(FUNC_TICK, 2'd0);
		send_item(FUNC_SET, 2'd2);
		send_item(FUNC_SET, 2'd0);
		send_item(FUNC_UNUSED, 2'd0);

		for (k = 0; k < SETTINGS_COUNT; k++) begin
			if (k == 2) begin
				tx_idle_pct = 83;
				rx_idle_pct <= 34;
			end else if (k == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			drain();
			repeat (4) @(posedge clk);
			configure(k);
			repeat (ITEMS_PER_SET) send_random_item();
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bps_pkg.sv
hw/rtl/bps_step.sv
hw/rtl/beep_pattern_sequencer.sv
tb/sv/beep_sequence_checker.sv
tb/sv/beep_pattern_sequencer_tb.sv
